// File: design/snd_pkg.sv
`timescale 1ns / 1ps
// Shared types, constants and the base decoder for the site nucleotide diversity block.
// No dependencies; snd_datapath, snd_ctrl and the top level import this package.
package snd_pkg;

    localparam int MAX_SEQUENCES_DEF = 256;
    localparam int FRACTION_BITS_DEF = 16;

    localparam int NUM_ALLELES = 4;
    localparam int NUM_COUNTS  = 5;
    localparam int OUT_FRAC_W  = 17;
    localparam int OUT_COUNT_W = 10;
    localparam int CFG_INDEX_W = 4;

    localparam logic [CFG_INDEX_W-1:0] REG_INBRED_MODE   = 4'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_USABLE_COLUMN = 4'd1;

    typedef enum logic [2:0] {
        ALLELE_A    = 3'd0,
        ALLELE_C    = 3'd1,
        ALLELE_G    = 3'd2,
        ALLELE_T    = 3'd3,
        ALLELE_NONE = 3'd4
    } allele_t;

    typedef struct packed {
        allele_t first;
        allele_t second;
    } decode_t;

    typedef struct packed {
        logic [7:0] base_code;
        logic       allele_pick;
        logic       last_in_column;
    } in_t;

    typedef struct packed {
        logic                   site_defined;
        logic                   segregating;
        logic [OUT_FRAC_W-1:0]  pi_estimate;
        logic [OUT_FRAC_W-1:0]  fourth_column;
        logic [OUT_COUNT_W-1:0] count_a;
        logic [OUT_COUNT_W-1:0] count_c;
        logic [OUT_COUNT_W-1:0] count_g;
        logic [OUT_COUNT_W-1:0] count_t;
        logic [OUT_COUNT_W-1:0] count_missing;
    } out_t;

    typedef enum logic [1:0] {
        MUL_IDLE = 2'd0,
        MUL_SQ   = 2'd1,
        MUL_NN   = 2'd2,
        MUL_ND   = 2'd3
    } mul_op_t;

    typedef enum logic {
        DIV_PI   = 1'b0,
        DIV_FRAC = 1'b1
    } div_sel_t;

    typedef enum logic [3:0] {
        ST_ACCUM,
        ST_SQ,
        ST_NN,
        ST_ND,
        ST_PI_START,
        ST_PI_WAIT,
        ST_FR_START,
        ST_FR_WAIT,
        ST_EMIT
    } state_t;

    typedef struct packed {
        logic        acc_en;
        mul_op_t     mul_op;
        logic [1:0]  sq_idx;
        logic        sq_first;
        logic        div_start;
        div_sel_t    div_sel;
        logic        cap_pi;
        logic        cap_frac;
        logic        load_out;
    } cmd_t;

    typedef struct packed {
        logic div_done;
        logic div_busy;
        logic out_free;
    } status_t;

    // Lower case letters fold to upper case; anything unknown is missing.
    function automatic decode_t decode_base(input logic [7:0] ch);
        logic [7:0] u;
        decode_t    d;
        u = (ch >= "a" && ch <= "z") ? ch - 8'd32 : ch;
        d.first  = ALLELE_NONE;
        d.second = ALLELE_NONE;
        case (u)
            "A": begin d.first = ALLELE_A; d.second = ALLELE_A; end
            "C": begin d.first = ALLELE_C; d.second = ALLELE_C; end
            "G": begin d.first = ALLELE_G; d.second = ALLELE_G; end
            "T": begin d.first = ALLELE_T; d.second = ALLELE_T; end
            "K": begin d.first = ALLELE_G; d.second = ALLELE_T; end
            "M": begin d.first = ALLELE_A; d.second = ALLELE_C; end
            "R": begin d.first = ALLELE_A; d.second = ALLELE_G; end
            "S": begin d.first = ALLELE_C; d.second = ALLELE_G; end
            "W": begin d.first = ALLELE_A; d.second = ALLELE_T; end
            "Y": begin d.first = ALLELE_C; d.second = ALLELE_T; end
            default: begin d.first = ALLELE_NONE; d.second = ALLELE_NONE; end
        endcase
        return d;
    endfunction

endpackage

// File: design/snd_div.sv
`timescale 1ns / 1ps
// Restoring fraction divider: floor(num * 2^FRACTION_BITS / den) for num <= den.
// One quotient bit per cycle; depends on nothing but the clock and reset.
module snd_div #(
    parameter int DW            = 24,
    parameter int FRACTION_BITS = 16
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     start,
    input  logic [DW-1:0]            num,
    input  logic [DW-1:0]            den,
    output logic                     busy,
    output logic                     done,
    output logic [FRACTION_BITS:0]   quot
);

    localparam int CNTW = $clog2(FRACTION_BITS);

    logic                   busy_reg, busy_next;
    logic                   done_reg, done_next;
    logic [CNTW-1:0]        cnt_reg, cnt_next;
    logic [DW-1:0]          r_reg, r_next;
    logic [DW-1:0]          den_reg, den_next;
    logic                   zero_reg, zero_next;
    logic [FRACTION_BITS:0] q_reg, q_next;
    logic [DW:0]            r_shift;
    logic [DW:0]            r_diff;
    logic                   fits;

    assign r_shift = {r_reg, 1'b0};
    assign r_diff  = r_shift - {1'b0, den_reg};
    assign fits    = r_shift >= {1'b0, den_reg};

    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        r_next    = r_reg;
        den_next  = den_reg;
        zero_next = zero_reg;
        q_next    = q_reg;
        if (start) begin
            busy_next = 1'b1;
            cnt_next  = '0;
            den_next  = den;
            zero_next = (den == '0);
            // The integer part is 0 or 1 because num never exceeds den.
            if (num >= den) begin
                q_next = (FRACTION_BITS+1)'(1);
                r_next = num - den;
            end else begin
                q_next = '0;
                r_next = num;
            end
        end else if (busy_reg) begin
            q_next = {q_reg[FRACTION_BITS-1:0], fits};
            r_next = fits ? r_diff[DW-1:0] : r_shift[DW-1:0];
            cnt_next = cnt_reg + CNTW'(1);
            if (cnt_reg == CNTW'(FRACTION_BITS - 1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        r_reg    <= r_next;
        den_reg  <= den_next;
        zero_reg <= zero_next;
        q_reg    <= q_next;
    end

    assign busy = busy_reg;
    assign done = done_reg;
    assign quot = zero_reg ? '0 : q_reg;

endmodule

// File: design/snd_datapath.sv
`timescale 1ns / 1ps
// Datapath: configuration registers, allele counters, the shared multiplier,
// the fraction divider and the output register. Uses snd_pkg and snd_div.
module snd_datapath import snd_pkg::*; #(
    parameter int MAX_SEQUENCES = MAX_SEQUENCES_DEF,
    parameter int FRACTION_BITS = FRACTION_BITS_DEF
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   cfg_valid,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic                   cfg_data,
    input  in_t                    s_data,
    input  cmd_t                   cmd,
    output status_t                status,
    output logic                   m_valid,
    input  logic                   m_ready,
    output out_t                   m_data
);

    localparam int COUNT_LIMIT = 2 * MAX_SEQUENCES;
    localparam int CW = $clog2(COUNT_LIMIT + 1);
    localparam int NW = CW + 2;
    localparam int TW = CW + 3;
    localparam int PW = 2 * NW;
    localparam int QW = FRACTION_BITS + 1;

    logic            inbred_mode_reg;
    logic            usable_column_reg;
    logic [CW-1:0]   counts_reg [NUM_COUNTS];
    logic [CW-1:0]   counts_next [NUM_COUNTS];
    logic [1:0]      inc [NUM_COUNTS];
    logic [CW:0]     sum [NUM_COUNTS];
    decode_t         dec;
    allele_t         pick_allele;
    logic [1:0]      amt;

    logic [NW-1:0]   n_reg;
    logic [TW-1:0]   total_reg;
    logic [PW-1:0]   sumsq_reg, nn_reg, den_reg, num_reg;
    logic [QW-1:0]   pi_reg, frac_reg;
    logic            out_valid_reg;
    out_t            out_reg, out_next;

    logic [NW-1:0]   n_sum;
    logic [TW-1:0]   total_sum;
    logic [CW-1:0]   sq_operand;
    logic [NW-1:0]   mul_a, mul_b;
    logic [PW-1:0]   prod;
    logic            site_defined;
    logic [PW-1:0]   div_num, div_den;
    logic            div_busy, div_done;
    logic [QW-1:0]   div_quot;
    logic [QW-1:0]   fourth_raw;
    logic [QW+OUT_FRAC_W-1:0] pi_wide, fourth_wide;

    // ---------------- allele accumulation ----------------
    assign dec         = decode_base(s_data.base_code);
    assign pick_allele = s_data.allele_pick ? dec.second : dec.first;
    assign amt         = inbred_mode_reg ? 2'd1 : 2'd2;

    always_comb begin
        for (int k = 0; k < NUM_COUNTS; k++) begin
            inc[k] = 2'd0;
            if (dec.first == dec.second) begin
                // Plain bases and missing characters alike.
                if (dec.first == allele_t'(3'(k))) inc[k] = amt;
            end else if (inbred_mode_reg) begin
                if (pick_allele == allele_t'(3'(k))) inc[k] = 2'd1;
            end else if (dec.first == allele_t'(3'(k)) || dec.second == allele_t'(3'(k))) begin
                inc[k] = 2'd1;
            end
            sum[k] = {1'b0, counts_reg[k]} + (CW+1)'(inc[k]);
            if (cmd.load_out) begin
                counts_next[k] = '0;
            end else if (cmd.acc_en) begin
                counts_next[k] = (sum[k] > (CW+1)'(COUNT_LIMIT)) ? CW'(COUNT_LIMIT)
                                                                 : sum[k][CW-1:0];
            end else begin
                counts_next[k] = counts_reg[k];
            end
        end
    end

    // ---------------- column arithmetic ----------------
    assign n_sum = NW'(counts_reg[ALLELE_A]) + NW'(counts_reg[ALLELE_C])
                 + NW'(counts_reg[ALLELE_G]) + NW'(counts_reg[ALLELE_T]);
    assign total_sum  = TW'(n_sum) + TW'(counts_reg[ALLELE_NONE]);
    assign sq_operand = counts_reg[{1'b0, cmd.sq_idx}];

    always_comb begin
        case (cmd.mul_op)
            MUL_SQ: begin
                mul_a = NW'(sq_operand);
                mul_b = NW'(sq_operand);
            end
            MUL_NN: begin
                mul_a = n_reg;
                mul_b = n_reg;
            end
            MUL_ND: begin
                mul_a = n_reg;
                mul_b = n_reg - NW'(1);
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign prod         = mul_a * mul_b;
    assign site_defined = n_reg > NW'(1);

    assign div_num = (cmd.div_sel == DIV_PI) ? num_reg : PW'(n_reg);
    assign div_den = (cmd.div_sel == DIV_PI) ? (site_defined ? den_reg : '0)
                                             : PW'(total_reg);

    snd_div #(
        .DW            (PW),
        .FRACTION_BITS (FRACTION_BITS)
    ) u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (cmd.div_start),
        .num     (div_num),
        .den     (div_den),
        .busy    (div_busy),
        .done    (div_done),
        .quot    (div_quot)
    );

    // ---------------- result assembly ----------------
    always_comb begin
        if (usable_column_reg) begin
            fourth_raw = frac_reg;
        end else begin
            fourth_raw = site_defined ? '0 : {1'b1, {FRACTION_BITS{1'b0}}};
        end
    end

    assign pi_wide     = {{OUT_FRAC_W{1'b0}}, pi_reg};
    assign fourth_wide = {{OUT_FRAC_W{1'b0}}, fourth_raw};

    always_comb begin
        out_next.site_defined  = site_defined;
        out_next.segregating   = site_defined && (num_reg != '0);
        out_next.pi_estimate   = pi_wide[OUT_FRAC_W-1:0];
        out_next.fourth_column = fourth_wide[OUT_FRAC_W-1:0];
        out_next.count_a       = OUT_COUNT_W'({{OUT_COUNT_W{1'b0}}, counts_reg[ALLELE_A]});
        out_next.count_c       = OUT_COUNT_W'({{OUT_COUNT_W{1'b0}}, counts_reg[ALLELE_C]});
        out_next.count_g       = OUT_COUNT_W'({{OUT_COUNT_W{1'b0}}, counts_reg[ALLELE_G]});
        out_next.count_t       = OUT_COUNT_W'({{OUT_COUNT_W{1'b0}}, counts_reg[ALLELE_T]});
        out_next.count_missing = OUT_COUNT_W'({{OUT_COUNT_W{1'b0}}, counts_reg[ALLELE_NONE]});
    end

    // ---------------- registers ----------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            inbred_mode_reg   <= 1'b0;
            usable_column_reg <= 1'b0;
            out_valid_reg     <= 1'b0;
            for (int k = 0; k < NUM_COUNTS; k++) begin
                counts_reg[k] <= '0;
            end
        end else begin
            if (cfg_valid && cfg_index == REG_INBRED_MODE) begin
                inbred_mode_reg <= cfg_data;
            end
            if (cfg_valid && cfg_index == REG_USABLE_COLUMN) begin
                usable_column_reg <= cfg_data;
            end
            for (int k = 0; k < NUM_COUNTS; k++) begin
                counts_reg[k] <= counts_next[k];
            end
            if (cmd.load_out) begin
                out_valid_reg <= 1'b1;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.mul_op == MUL_SQ) begin
            if (cmd.sq_first) begin
                n_reg     <= n_sum;
                total_reg <= total_sum;
                sumsq_reg <= prod;
            end else begin
                sumsq_reg <= sumsq_reg + prod;
            end
        end
        if (cmd.mul_op == MUL_NN) begin
            nn_reg <= prod;
        end
        if (cmd.mul_op == MUL_ND) begin
            den_reg <= prod;
            num_reg <= nn_reg - sumsq_reg;
        end
        if (cmd.cap_pi) begin
            pi_reg <= div_quot;
        end
        if (cmd.cap_frac) begin
            frac_reg <= div_quot;
        end
        if (cmd.load_out) begin
            out_reg <= out_next;
        end
    end

    assign status.div_done = div_done;
    assign status.div_busy = div_busy;
    assign status.out_free = !out_valid_reg || m_ready;
    assign m_valid         = out_valid_reg;
    assign m_data          = out_reg;

endmodule

// File: design/snd_ctrl.sv
`timescale 1ns / 1ps
// Controller: sequences accumulation, the sum of squares, the two divisions
// and the hand-off to the output register. Uses snd_pkg.
module snd_ctrl import snd_pkg::*; (
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    s_valid,
    input  logic    s_last,
    output logic    s_ready,
    input  status_t status,
    output cmd_t    cmd
);

    state_t     state_reg, state_next;
    logic [1:0] sq_idx_reg, sq_idx_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= ST_ACCUM;
            sq_idx_reg <= '0;
        end else begin
            state_reg  <= state_next;
            sq_idx_reg <= sq_idx_next;
        end
    end

    always_comb begin
        state_next    = state_reg;
        sq_idx_next   = sq_idx_reg;
        s_ready       = 1'b0;
        cmd.acc_en    = 1'b0;
        cmd.mul_op    = MUL_IDLE;
        cmd.sq_idx    = sq_idx_reg;
        cmd.sq_first  = 1'b0;
        cmd.div_start = 1'b0;
        cmd.div_sel   = DIV_PI;
        cmd.cap_pi    = 1'b0;
        cmd.cap_frac  = 1'b0;
        cmd.load_out  = 1'b0;
        case (state_reg)
            ST_ACCUM: begin
                s_ready    = 1'b1;
                cmd.acc_en = s_valid;
                if (s_valid && s_last) begin
                    sq_idx_next = '0;
                    state_next  = ST_SQ;
                end
            end
            ST_SQ: begin
                cmd.mul_op   = MUL_SQ;
                cmd.sq_first = (sq_idx_reg == '0);
                sq_idx_next  = sq_idx_reg + 2'd1;
                if (sq_idx_reg == 2'(NUM_ALLELES - 1)) begin
                    state_next = ST_NN;
                end
            end
            ST_NN: begin
                cmd.mul_op = MUL_NN;
                state_next = ST_ND;
            end
            ST_ND: begin
                cmd.mul_op = MUL_ND;
                state_next = ST_PI_START;
            end
            ST_PI_START: begin
                cmd.div_start = 1'b1;
                cmd.div_sel   = DIV_PI;
                state_next    = ST_PI_WAIT;
            end
            ST_PI_WAIT: begin
                if (status.div_done) begin
                    cmd.cap_pi = 1'b1;
                    state_next = ST_FR_START;
                end
            end
            ST_FR_START: begin
                cmd.div_start = 1'b1;
                cmd.div_sel   = DIV_FRAC;
                state_next    = ST_FR_WAIT;
            end
            ST_FR_WAIT: begin
                cmd.div_sel = DIV_FRAC;
                if (status.div_done) begin
                    cmd.cap_frac = 1'b1;
                    state_next   = ST_EMIT;
                end
            end
            ST_EMIT: begin
                // Hold here while the previous column's word is still unread.
                if (status.out_free) begin
                    cmd.load_out = 1'b1;
                    state_next   = ST_ACCUM;
                end
            end
            default: begin
                state_next = ST_ACCUM;
            end
        endcase
    end

endmodule

// File: design/site_nucleotide_diversity_core.sv
`timescale 1ns / 1ps
// Per-site nucleotide diversity (pi) estimator for one alignment column at a time.
// Top level; uses snd_pkg, snd_ctrl and snd_datapath (which holds snd_div).
//
// Usage:
//   s_valid/s_ready/s_data: one word per sequence, holding the base character,
//   the allele pick bit for inbred heterozygous codes and the end-of-column mark.
//   m_valid/m_ready/m_data: one word per column with site_defined, segregating,
//   pi and the fourth column in Q1.FRACTION_BITS, and the five allele counts.
//   cfg_valid/cfg_ready/cfg_index/cfg_data: register 0 selects inbred mode,
//   register 1 selects the usable fraction for the fourth column. cfg_ready is
//   always high; writes belong between columns.
// Timing: within a column one word is taken every cycle. After the word that
// ends a column, s_ready stays low while the column is reduced: squaring of the
// four allele counts through the single multiplier, two more products, then two
// divisions on the shared radix-2 divider at one quotient bit a cycle.
// A pending result sits in the output register; the next column is accepted
// meanwhile, and only its own result waits until m_ready frees the register.
// Reset clears the counters, both configuration registers and m_valid.
module site_nucleotide_diversity_core import snd_pkg::*; #(
    parameter int MAX_SEQUENCES = MAX_SEQUENCES_DEF,
    parameter int FRACTION_BITS = FRACTION_BITS_DEF
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic                   cfg_data,
    input  logic                   s_valid,
    output logic                   s_ready,
    input  in_t                    s_data,
    output logic                   m_valid,
    input  logic                   m_ready,
    output out_t                   m_data
);

    cmd_t    cmd;
    status_t status;

    assign cfg_ready = 1'b1;

    snd_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_last  (s_data.last_in_column),
        .s_ready (s_ready),
        .status  (status),
        .cmd     (cmd)
    );

    snd_datapath #(
        .MAX_SEQUENCES (MAX_SEQUENCES),
        .FRACTION_BITS (FRACTION_BITS)
    ) u_datapath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_data    (s_data),
        .cmd       (cmd),
        .status    (status),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

    // The column end must stop intake until the result has been formed.
    a_last_stalls: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && s_data.last_in_column |=> !s_ready)
        else $error("input accepted right after the end of a column");

    // A new result never overwrites one that is still unread.
    a_load_free: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.load_out |-> status.out_free)
        else $error("output register loaded while occupied");

    // The divider is only started when idle.
    a_div_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.div_start |-> !status.div_busy)
        else $error("divider started while busy");

    // m_valid rises only from a load by the controller.
    a_mvalid_src: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> $past(cmd.load_out))
        else $error("result word appeared without a load");

endmodule
